@@ hw/rtl/vertex_transform_normalize_assert.svh @@
// Assertion macros for the vertex transform pipeline.
`ifndef VERTEX_TRANSFORM_NORMALIZE_ASSERT_SVH
`define VERTEX_TRANSFORM_NORMALIZE_ASSERT_SVH
`ifndef SYNTHESIS
`define VTN_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define VTN_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define VTN_ASSERT(label, clk, rst_n, prop)
`define VTN_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ hw/rtl/vtn_pkg.sv @@
// Shared constants for the vertex transform pipeline.
package vtn_pkg;
  localparam int unsigned NumRegs   = 7;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned RegDataW  = 64;
  localparam logic [RegIdxW-1:0] RegTanEn = 3'd6;
  localparam int unsigned Lanes     = 6;
  localparam int unsigned InDataW   = 288;
  localparam int unsigned OutDataW  = 256;
endpackage

@@ hw/rtl/vtn_norm.sv @@
// Pipelined renormalization of one three-component vector to unit length.
module vtn_norm #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [WORD_BITS-1:0] vec_i [3],
  output logic signed [WORD_BITS-1:0] unit_o [3]
);
  // mag <= 2^(W-1) fits W bits; after scaling magnitudes stay at or below 2^31.
  localparam int unsigned MW   = 32;
  localparam int unsigned SW   = 64;
  localparam int unsigned LW   = 33;
  localparam int unsigned NumW = MW + FRAC_BITS + 1;
  localparam int unsigned QW   = FRAC_BITS + 2;
  localparam int unsigned ShW  = 5;
  localparam int unsigned SqIt = 32;
  localparam int unsigned DvIt = QW;

  // Stage A: magnitudes, signs, leading-bit normalize.
  logic [MW-1:0] mag_a [3];
  logic [2:0]    neg_a;
  logic [MW-1:0] mx_a;
  logic [ShW-1:0] sh_a;
  logic [MW-1:0] sm_q [3];
  logic [2:0]    neg_q;
  logic          zero_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_a[i] = vec_i[i][WORD_BITS-1];
      mag_a[i] = neg_a[i] ? MW'(-$signed({{(MW-WORD_BITS){vec_i[i][WORD_BITS-1]}}, vec_i[i]}))
                          : MW'({{(MW-WORD_BITS){1'b0}}, vec_i[i]});
    end
    mx_a = mag_a[0];
    if (mag_a[1] > mx_a) mx_a = mag_a[1];
    if (mag_a[2] > mx_a) mx_a = mag_a[2];
    sh_a = '0;
    for (int b = 0; b < 31; b++) begin
      if (mx_a[b]) sh_a = ShW'(30 - b);
    end
    if (mx_a[31] || mx_a[30]) sh_a = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sm_q[i] <= mag_a[i] << sh_a;
      neg_q  <= neg_a;
      zero_q <= (mx_a == '0);
    end
  end

  // Stage B: squares, one multiplier per lane.
  logic [SW-1:0] sq_q [3];
  logic [MW-1:0] smb_q [3];
  logic [2:0]    negb_q;
  logic          zerob_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= SW'(sm_q[i]) * SW'(sm_q[i]);
      smb_q <= sm_q; negb_q <= neg_q; zerob_q <= zero_q;
    end
  end

  // Stage C: sum of squares (fits 64 bits, max 3*2^62).
  logic [SW-1:0] ss_q;
  logic [MW-1:0] smc_q [3];
  logic [2:0]    negc_q;
  logic          zeroc_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ss_q <= sq_q[0] + sq_q[1] + sq_q[2];
      smc_q <= smb_q; negc_q <= negb_q; zeroc_q <= zerob_q;
    end
  end

  // Square root pipeline: one result bit per stage.
  logic [SW-1:0] rx_q  [SqIt+1];
  logic [LW-1:0] rr_q  [SqIt+1];
  logic [MW-1:0] rsm_q [SqIt+1][3];
  logic [2:0]    rneg_q  [SqIt+1];
  logic          rzero_q [SqIt+1];

  always_comb begin
    rx_q[0] = ss_q; rr_q[0] = '0; rsm_q[0] = smc_q;
    rneg_q[0] = negc_q; rzero_q[0] = zeroc_q;
  end

  for (genvar k = 0; k < SqIt; k++) begin : g_sqrt
    localparam int unsigned Bp = 2 * (SqIt - 1 - k);
    logic [SW+1:0] trial;
    logic [SW-1:0] rem;
    assign trial = {2'b00, rx_q[k]} - (({{(SW+2-LW){1'b0}}, rr_q[k]} << (Bp + 2))
                   + ((SW+2)'(1) << Bp));
    assign rem = SW'(trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!trial[SW+1]) begin
          rx_q[k+1] <= rem;
          rr_q[k+1] <= (rr_q[k] << 1) | LW'(1);
        end else begin
          rx_q[k+1] <= rx_q[k];
          rr_q[k+1] <= rr_q[k] << 1;
        end
        rsm_q[k+1] <= rsm_q[k]; rneg_q[k+1] <= rneg_q[k]; rzero_q[k+1] <= rzero_q[k];
      end
    end
  end

  // Divide pipeline: numerator (mag << F) + L/2, one quotient bit per stage.
  logic [NumW-1:0] dn_q  [3][DvIt+1];
  logic [QW-1:0]   dq_q  [3][DvIt+1];
  logic [LW-1:0]   dl_q  [DvIt+1];
  logic [2:0]      dneg_q  [DvIt+1];
  logic            dzero_q [DvIt+1];

  always_comb begin
    dl_q[0] = rr_q[SqIt];
    dneg_q[0] = rneg_q[SqIt];
    dzero_q[0] = rzero_q[SqIt];
    for (int i = 0; i < 3; i++) begin
      dn_q[i][0] = (NumW'(rsm_q[SqIt][i]) << FRAC_BITS) + NumW'(rr_q[SqIt] >> 1);
      dq_q[i][0] = '0;
    end
  end

  for (genvar k = 0; k < DvIt; k++) begin : g_div
    localparam int unsigned Bp = DvIt - 1 - k;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [NumW+QW:0] dsub;
      logic [NumW+QW:0] dval;
      assign dval = (NumW+QW+1)'(dl_q[k]) << Bp;
      assign dsub = (NumW+QW+1)'(dn_q[i][k]) - dval;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!dsub[NumW+QW]) begin
            dn_q[i][k+1] <= NumW'(dsub);
            dq_q[i][k+1] <= dq_q[i][k] | (QW'(1) << Bp);
          end else begin
            dn_q[i][k+1] <= dn_q[i][k];
            dq_q[i][k+1] <= dq_q[i][k];
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dl_q[k+1] <= dl_q[k]; dneg_q[k+1] <= dneg_q[k]; dzero_q[k+1] <= dzero_q[k];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dzero_q[DvIt]) unit_o[i] = '0;
      else if (dneg_q[DvIt][i])
        unit_o[i] = -$signed(WORD_BITS'({{(WORD_BITS-QW){1'b0}}, dq_q[i][DvIt]}));
      else unit_o[i] = $signed(WORD_BITS'({{(WORD_BITS-QW){1'b0}}, dq_q[i][DvIt]}));
    end
  end
endmodule

@@ hw/rtl/vertex_transform_normalize.sv @@
// Vertex transform top level: affine position product, rotated and renormalized normals and tangents, pipeline control.
// The matrix product is followed by 3 + 32 + (FRAC_BITS+2) renormalize stages.
// Throughput: one vertex per cycle while the output is not stalled; the square-root and divide pipelines set the depth.
// A stall on the output freezes every stage at once, so nothing is lost or repeated.
// Reset (asynchronous, active low) clears the stage valid bits and loads the reset matrix.
// Tangent enable resets to zero.
module vertex_transform_normalize #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vtn_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  logic [vtn_pkg::RegDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tan_x, tan_y, tan_z (32 bits each)
  input  logic [vtn_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_pos_x/y/z (32 each), out_norm_x/y/z (18 each), out_tan_x/y/z (32 each), 10 pad
  output logic [vtn_pkg::OutDataW-1:0]  m_axis_tdata
);
  `include "vertex_transform_normalize_assert.svh"
  import vtn_pkg::*;

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned SW  = 2 * W + 3;
  localparam int unsigned SqIt = 32;
  localparam int unsigned NDepth = 3 + SqIt + FRAC_BITS + 2;
  localparam int unsigned Depth = 4 + NDepth;

  logic [RegDataW-1:0] mat_q [6];
  logic                tan_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= 64'h0000_0000_0001_0000;
      mat_q[1] <= '0;
      mat_q[2] <= 64'h0001_0000_0000_0000;
      mat_q[3] <= '0;
      mat_q[4] <= '0;
      mat_q[5] <= 64'h0000_0000_0001_0000;
      tan_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegTanEn) tan_en_q <= cfg_data_i[0];
      else if (cfg_idx_i < RegTanEn) mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  function automatic logic signed [W-1:0] melem(logic [RegDataW-1:0] m [6], int r, int c);
    logic [RegDataW-1:0] w;
    w = m[r*2 + c/2];
    return (c % 2 == 1) ? $signed(w[32 +: W]) : $signed(w[0 +: W]);
  endfunction

  // Whole pipeline advances together.
  logic en;
  logic [Depth-1:0] vld_q;
  assign en = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
  end

  // Stage 1: register inputs.
  logic signed [W-1:0] v1_q [9];
  logic [31:0]         tin_q [Depth][3];
  logic                ten_q [Depth];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) v1_q[i] <= $signed(s_axis_tdata[32*i +: W]);
      for (int i = 0; i < 3; i++) tin_q[0][i] <= s_axis_tdata[32*(6+i) +: 32];
      ten_q[0] <= tan_en_q;
      for (int d = 1; d < Depth; d++) begin
        tin_q[d] <= tin_q[d-1];
        ten_q[d] <= ten_q[d-1];
      end
    end
  end

  // Stage 2: 27 products (3 vectors x 3 rows x 3 columns), one multiplier each.
  logic signed [PW-1:0] p2_q [3][3][3];
  logic signed [W-1:0]  tr2_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 3; v++)
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            p2_q[v][r][c] <= PW'(melem(mat_q, r, c)) * PW'(v1_q[3*v + c]);
      for (int r = 0; r < 3; r++) tr2_q[r] <= melem(mat_q, r, 3);
    end
  end

  // Stage 3: exact sums with rounding half.
  logic signed [SW-1:0] s3_q [3][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 3; v++)
        for (int r = 0; r < 3; r++)
          s3_q[v][r] <= SW'(p2_q[v][r][0]) + SW'(p2_q[v][r][1]) + SW'(p2_q[v][r][2])
                        + ((v == 0) ? (SW'(tr2_q[r]) <<< FRAC_BITS) : SW'(0))
                        + (SW'(1) <<< (FRAC_BITS - 1));
    end
  end

  // Stage 4: shift and saturate.
  logic signed [W-1:0] r4_q [3][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 3; v++)
        for (int r = 0; r < 3; r++) begin
          logic signed [SW-1:0] sh;
          sh = s3_q[v][r] >>> FRAC_BITS;
          if (sh > SW'((64'sd1 <<< (W-1)) - 1)) r4_q[v][r] <= {1'b0, {(W-1){1'b1}}};
          else if (sh < -SW'(64'sd1 <<< (W-1))) r4_q[v][r] <= {1'b1, {(W-1){1'b0}}};
          else r4_q[v][r] <= W'(sh);
        end
    end
  end

  logic signed [W-1:0] pos_q [NDepth][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q[0] <= r4_q[0];
      for (int d = 1; d < NDepth; d++) pos_q[d] <= pos_q[d-1];
    end
  end

  logic signed [W-1:0] nu [3];
  logic signed [W-1:0] tu [3];
  vtn_norm #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(W)) u_norm_n (
    .clk_i, .en_i(en), .vec_i(r4_q[1]), .unit_o(nu));
  vtn_norm #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(W)) u_norm_t (
    .clk_i, .en_i(en), .vec_i(r4_q[2]), .unit_o(tu));

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata[32*i +: 32]      = 32'($signed(pos_q[NDepth-1][i]));
      m_axis_tdata[96 + 18*i +: 18] = 18'(nu[i]);
      m_axis_tdata[150 + 32*i +: 32] = ten_q[Depth-1] ? 32'($signed(tu[i]))
                                                       : tin_q[Depth-1][i];
    end
  end

  `VTN_ASSERT(a_stall_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
  `VTN_ASSERT(a_ready_stall, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
  `VTN_ASSERT_RST(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid)
endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the vertex transform and renormalization pipeline.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vtn_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned ResultW = 246;
  localparam int unsigned DrainCycles = 90;
  localparam logic [RegIdxW-1:0] RegRow0Cols01 = 3'd0;
  localparam logic [RegIdxW-1:0] RegRow0Cols23 = 3'd1;
  localparam logic [RegIdxW-1:0] RegRow1Cols01 = 3'd2;
  localparam logic [RegIdxW-1:0] RegRow1Cols23 = 3'd3;
  localparam logic [RegIdxW-1:0] RegRow2Cols01 = 3'd4;
  localparam logic [RegIdxW-1:0] RegRow2Cols23 = 3'd5;
  localparam logic [RegIdxW-1:0] RegUnused = 3'd7;

  typedef logic [31:0] vertex_t [9];
  typedef logic [31:0] vec3_t [3];
  typedef logic signed [63:0] unit3_t [3];

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [RegIdxW-1:0] cfg_idx_i;
  logic [RegDataW-1:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  logic [63:0] matrix_q [6];
  bit tangent_on;
  logic [ResultW-1:0] expected_vertices [$];
  int mismatches;
  int src_idle_pct;
  int snk_stall_pct;
  int stall_hold;

  int field_off [9] = '{0, 32, 64, 96, 114, 132, 150, 182, 214};
  int field_w [9] = '{32, 32, 32, 18, 18, 18, 32, 32, 32};
  string field_name [9] = '{"out_pos_x", "out_pos_y", "out_pos_z", "out_norm_x",
    "out_norm_y", "out_norm_z", "out_tan_x", "out_tan_y", "out_tan_z"};

  vertex_transform_normalize i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic signed [31:0] matrix_at(int r, int c);
    logic [63:0] w;
    w = matrix_q[r * 2 + c / 2];
    return (c % 2) ? w[63:32] : w[31:0];
  endfunction

  function automatic logic [31:0] row_product(int r, vec3_t v, bit with_trans);
    logic signed [95:0] acc;
    acc = 0;
    for (int c = 0; c < 3; c++) acc = acc + matrix_at(r, c) * $signed(v[c]);
    if (with_trans) acc = acc + matrix_at(r, 3) * (96'sd1 <<< FracBits);
    acc = (acc + (96'sd1 <<< (FracBits - 1))) >>> FracBits;
    if (acc > 96'sd2147483647) acc = 96'sd2147483647;
    if (acc < -96'sd2147483648) acc = -96'sd2147483648;
    return acc[31:0];
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x = x - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic unit3_t unit_vector(vec3_t v);
    longint unsigned mag [3];
    longint unsigned top;
    longint unsigned sq;
    longint unsigned len;
    longint unsigned q;
    longint sv;
    unit3_t o;
    top = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      sv = longint'($signed(v[i]));
      mag[i] = (sv < 0) ? -sv : sv;
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) begin
      o = '{0, 0, 0};
      return o;
    end
    while (top < (64'd1 << 30)) begin
      top = top << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) sq = sq + mag[i] * mag[i];
    len = floor_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FracBits) + (len >> 1)) / len;
      o[i] = $signed(v[i]) < 0 ? -$signed(q) : $signed(q);
    end
    return o;
  endfunction

  function automatic logic [ResultW-1:0] transform_vertex(vertex_t vin);
    vec3_t p, n, t, rot;
    unit3_t u;
    logic [ResultW-1:0] r;
    for (int i = 0; i < 3; i++) begin
      p[i] = vin[i];
      n[i] = vin[3 + i];
      t[i] = vin[6 + i];
    end
    r = '0;
    for (int i = 0; i < 3; i++) r[32 * i +: 32] = row_product(i, p, 1'b1);
    for (int i = 0; i < 3; i++) rot[i] = row_product(i, n, 1'b0);
    u = unit_vector(rot);
    for (int i = 0; i < 3; i++) r[96 + 18 * i +: 18] = u[i][17:0];
    if (tangent_on) begin
      for (int i = 0; i < 3; i++) rot[i] = row_product(i, t, 1'b0);
      u = unit_vector(rot);
      for (int i = 0; i < 3; i++) r[150 + 32 * i +: 32] = u[i][31:0];
    end else begin
      for (int i = 0; i < 3; i++) r[150 + 32 * i +: 32] = t[i];
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    logic [ResultW-1:0] want;
    logic [31:0] e, a, mask;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transfer %h", m_axis_tdata);
      end else begin
        want = expected_vertices.pop_front();
        for (int f = 0; f < 9; f++) begin
          mask = (field_w[f] == 32) ? 32'hffffffff : ((32'd1 << field_w[f]) - 1);
          e = 32'(want >> field_off[f]) & mask;
          a = 32'(m_axis_tdata >> field_off[f]) & mask;
          if (e !== a) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%s mismatch: expected %h, got %h", field_name[f], e, a);
          end
        end
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_hold > 0) begin
        stall_hold--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_vertex(vertex_t vin);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    for (int i = 0; i < 9; i++) s_axis_tdata[32 * i +: 32] = vin[i];
    do @(posedge clk_i); while (!s_axis_tready);
    expected_vertices.insert(expected_vertices.size(), transform_vertex(vin));
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (expected_vertices.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [63:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx < RegTanEn) matrix_q[idx] = data;
    else if (idx == RegTanEn) tangent_on = data[0];
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 262143)) - 131072);
      2: return 32'($signed($urandom_range(0, 33554431)) - 16777216);
      3: return 32'h0;
      4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1, 2: return 32'($signed($urandom_range(0, 262143)) - 131072);
      3: return 32'h0;
      default: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    for (int i = 0; i < 9; i++) v[i] = rand_word();
    return v;
  endfunction

  task automatic random_config();
    for (int r = 0; r < 6; r++) write_reg(r[RegIdxW-1:0], {rand_coef(), rand_coef()});
    write_reg(RegTanEn, {63'($urandom()), 1'($urandom())});
  endtask

  task automatic fill_vertex(output vertex_t v, input logic [31:0] w);
    for (int i = 0; i < 9; i++) v[i] = w;
  endtask

  task automatic test_reset_matrix();
    vertex_t v;
    fill_vertex(v, 32'h00010000);
    send_vertex(v);
    fill_vertex(v, 32'h0);
    send_vertex(v);
    v = '{32'h7fffffff, 32'h80000000, 32'h00008000, 32'h00030000, 32'hfffc0000,
          32'h0, 32'h1, 32'h0, 32'h0};
    send_vertex(v);
    drain();
  endtask

  task automatic test_extremes();
    vertex_t v;
    write_reg(RegTanEn, 64'd1);
    fill_vertex(v, 32'h7fffffff);
    send_vertex(v);
    fill_vertex(v, 32'h80000000);
    send_vertex(v);
    fill_vertex(v, 32'h00000001);
    send_vertex(v);
    drain();
    for (int r = 0; r < 6; r++) write_reg(r[RegIdxW-1:0], 64'h7fffffff_7fffffff);
    fill_vertex(v, 32'h7fffffff);
    send_vertex(v);
    fill_vertex(v, 32'h80000000);
    send_vertex(v);
    drain();
    for (int r = 0; r < 6; r++) write_reg(r[RegIdxW-1:0], 64'h80000000_80000000);
    fill_vertex(v, 32'h7fffffff);
    send_vertex(v);
    fill_vertex(v, 32'hffffffff);
    send_vertex(v);
    drain();
    for (int r = 0; r < 6; r++) write_reg(r[RegIdxW-1:0], 64'hffffffff_ffffffff);
    send_vertex(v);
    drain();
    for (int r = 0; r < 6; r++) write_reg(r[RegIdxW-1:0], 64'h0);
    fill_vertex(v, 32'h12345678);
    send_vertex(v);
    drain();
    write_reg(RegTanEn, 64'hffffffff_fffffffe);
    send_vertex(v);
    drain();
  endtask

  task automatic test_unused_index();
    vertex_t v;
    write_reg(RegRow0Cols01, 64'h00000000_00020000);
    write_reg(RegRow0Cols23, 64'h00010000_00000000);
    write_reg(RegRow1Cols01, 64'h00020000_00000000);
    write_reg(RegRow1Cols23, 64'hffff0000_00000000);
    write_reg(RegRow2Cols01, 64'h0);
    write_reg(RegRow2Cols23, 64'h00008000_00020000);
    write_reg(RegTanEn, 64'd1);
    write_reg(RegUnused, 64'hffffffff_ffffffff);
    v = '{32'h00010000, 32'hffff8000, 32'h00040000, 32'h0, 32'h0, 32'h0,
          32'h00000010, 32'hfffffff0, 32'h0};
    send_vertex(v);
    drain();
  endtask

  task automatic test_random_phases();
    int idle_pct [4] = '{0, 52, 0, 33};
    int stall_pct [4] = '{0, 0, 52, 33};
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      src_idle_pct = idle_pct[ph % 4];
      snk_stall_pct = stall_pct[ph % 4];
      repeat (140) send_vertex(rand_vertex());
      drain();
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    random_config();
    stall_hold = 300;
    repeat (120) send_vertex(rand_vertex());
    drain();
    snk_stall_pct = 20;
    repeat (40) send_vertex(rand_vertex());
    drain();
    snk_stall_pct = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    mismatches = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    stall_hold = 0;
    matrix_q = '{64'h10000, 64'h0, 64'h00010000_00000000, 64'h0, 64'h0, 64'h10000};
    tangent_on = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_matrix();
    test_extremes();
    test_unused_index();
    test_random_phases();
    test_backpressure();
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
